FILE: src/lightmap_atlas_allocator_unit_macros.svh
// Assertion macros used by the checker of the atlas allocator.
`ifndef LIGHTMAP_ATLAS_ALLOCATOR_UNIT_MACROS_SVH
`define LIGHTMAP_ATLAS_ALLOCATOR_UNIT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define LAA_ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent in one cycle implies the consequent in the next cycle.
`define LAA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/laa_pkg.sv
// Types, constants and beat formats of the lightmap atlas allocator.
package laa_pkg;

    localparam int NUM_LAYERS = 64;
    localparam int ATLAS_SIZE = 128;

    localparam int LAYER_W = (NUM_LAYERS > 1) ? $clog2(NUM_LAYERS) : 1;
    localparam int COL_W   = $clog2(ATLAS_SIZE);
    localparam int HGT_W   = 8;

    typedef enum logic [0:0] {
        OP_ALLOC = 1'b0,
        OP_CLEAR = 1'b1
    } t_opcode;

    typedef struct packed {
        t_opcode    opcode;
        logic [7:0] rect_width;
        logic [7:0] rect_height;
    } t_in_beat;

    typedef struct packed {
        logic       success;
        logic [5:0] layer_index;
        logic [7:0] column_x;
        logic [7:0] row_y;
        logic [6:0] layers_in_use;
    } t_out_beat;

endpackage

FILE: src/lightmap_atlas_allocator_unit.sv
// Top level of the skyline rectangle allocator for a stack of square atlas layers.

// The block places rectangles in NUM_LAYERS square layers of ATLAS_SIZE columns,
// keeping a filled height per column in a synchronous column memory of
// NUM_LAYERS x ATLAS_SIZE bytes, plus a scratch memory of ATLAS_SIZE bytes.
// One request is handled at a time; the next input beat is taken as soon as
// the previous result has been moved to the output register, even if that
// result has not yet been collected. A clear beat, or an allocate beat with a
// zero or oversized dimension, goes straight from idle to the done state. An
// allocate beat walks the layers in use in order; each layer scanned takes two
// passes through the column memory at one column per cycle: a forward pass
// builds running maxima within blocks of rect_width columns, and a backward
// pass combines them with running maxima from the other side, so that every
// window maximum is known after the second pass. Placing into a layer already
// in use then writes rect_width columns. When no layer in use fits and one is
// left, the next layer is opened: its ATLAS_SIZE columns are written in one
// sweep (the new rectangle on the left, zero elsewhere), which is also how
// stale contents from before a clear or reset are removed, so no clearing pass
// is ever needed and a clear is instant.
module lightmap_atlas_allocator_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  laa_pkg::t_in_beat  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output laa_pkg::t_out_beat o_out_data
);
    import laa_pkg::*;

    localparam int COL_DEPTH = 1 << (LAYER_W + COL_W);
    localparam int SCR_DEPTH = 1 << COL_W;
    localparam logic [COL_W-1:0] LAST_X   = COL_W'(ATLAS_SIZE - 1);
    localparam logic [8:0]       SIZE_9   = 9'(ATLAS_SIZE);
    localparam logic [6:0]       LAYERS_7 = 7'(NUM_LAYERS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FWD,
        ST_BWD,
        ST_DECIDE,
        ST_WRITE,
        ST_INIT,
        ST_DONE
    } t_state;

    t_state            r_state;
    logic [7:0]        r_w;
    logic [7:0]        r_h;
    logic [LAYER_W-1:0] r_layer;
    logic [6:0]        r_used;

    // Scan pipeline: issue index, with the data stage in the cycle after it.
    logic [COL_W-1:0]  r_x;
    logic              r_iss;
    logic              r_dv;
    logic [COL_W-1:0]  r_dx;
    logic [7:0]        r_c;      // position of the data-stage column within its block
    logic [HGT_W-1:0]  r_pre;
    logic [HGT_W-1:0]  r_suf;
    logic [8:0]        r_best;
    logic [COL_W-1:0]  r_bx;
    logic [HGT_W-1:0]  r_new_h;
    logic [7:0]        r_k;

    t_out_beat         r_res;
    t_out_beat         r_out;
    logic              r_out_valid;

    // Memory connections.
    logic                        col_wr_en;
    logic [LAYER_W+COL_W-1:0]    col_addr;
    logic [HGT_W-1:0]            col_wr_data;
    logic [HGT_W-1:0]            col_q;
    logic                        scr_wr_en;
    logic [COL_W-1:0]            scr_rd_addr;
    logic [HGT_W-1:0]            scr_q;
    logic [8:0]                  scr_sum;

    // Data-stage arithmetic.
    logic [HGT_W-1:0]  pre_val;
    logic [HGT_W-1:0]  suf_val;
    logic [HGT_W-1:0]  score;
    logic              blk_end;
    logic [8:0]        lim_x;
    logic [8:0]        fit_sum;
    logic              req_bad;
    t_out_beat         res_start;
    t_out_beat         out_next;

    assign col_addr    = {r_layer, r_x};
    assign col_wr_en   = (r_state == ST_WRITE) || (r_state == ST_INIT);
    assign col_wr_data = (r_state == ST_WRITE) ? r_new_h
                       : ((9'(r_x) < 9'(r_w)) ? r_h : '0);

    assign scr_wr_en   = (r_state == ST_FWD) && r_dv;
    assign scr_sum     = 9'(r_x) + 9'(r_w) - 9'd1;
    assign scr_rd_addr = scr_sum[COL_W-1:0];

    laa_ram #(
        .WIDTH (HGT_W),
        .DEPTH (COL_DEPTH)
    ) u_col_ram (
        .i_clk     (i_clk),
        .i_wr_en   (col_wr_en),
        .i_wr_addr (col_addr),
        .i_wr_data (col_wr_data),
        .i_rd_addr (col_addr),
        .o_rd_data (col_q)
    );

    // Holds the block-wise running maxima of the forward pass.
    laa_ram #(
        .WIDTH (HGT_W),
        .DEPTH (SCR_DEPTH)
    ) u_scr_ram (
        .i_clk     (i_clk),
        .i_wr_en   (scr_wr_en),
        .i_wr_addr (r_dx),
        .i_wr_data (pre_val),
        .i_rd_addr (scr_rd_addr),
        .o_rd_data (scr_q)
    );

    always_comb begin
        // Blocks of rect_width columns are aligned to column zero; the forward
        // pass restarts its maximum at a block start, the backward pass at a
        // block end or at the last column.
        pre_val = (r_c == 8'd0) ? col_q : ((col_q > r_pre) ? col_q : r_pre);
        blk_end = (r_c == (r_w - 8'd1)) || (r_dx == LAST_X);
        suf_val = blk_end ? col_q : ((col_q > r_suf) ? col_q : r_suf);
        score   = (suf_val > scr_q) ? suf_val : scr_q;
        lim_x   = SIZE_9 - 9'(r_w);
        fit_sum = r_best + 9'(r_h);
        req_bad = (i_in_data.rect_width == 8'd0) || (i_in_data.rect_height == 8'd0)
               || (9'(i_in_data.rect_width) > SIZE_9)
               || (9'(i_in_data.rect_height) > SIZE_9);
        // A new request starts from an empty result; only a clear reports success
        // straight away.
        res_start         = '0;
        res_start.success = (i_in_data.opcode == OP_CLEAR);
        // The result beat carries the layer count as it stands after the request.
        out_next               = r_res;
        out_next.layers_in_use = r_used;
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_used      <= '0;
            r_iss       <= 1'b0;
            r_dv        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready && (r_state != ST_DONE)) begin
                r_out_valid <= 1'b0;
            end
            r_dv <= r_iss;
            r_dx <= r_x;

            unique case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_w     <= i_in_data.rect_width;
                        r_h     <= i_in_data.rect_height;
                        r_layer <= '0;
                        r_x     <= '0;
                        r_res   <= res_start;
                        if (i_in_data.opcode == OP_CLEAR) begin
                            r_used        <= '0;
                            r_state       <= ST_DONE;
                        end else if (req_bad) begin
                            r_state <= ST_DONE;
                        end else if (r_used == 7'd0) begin
                            r_state <= ST_INIT;
                        end else begin
                            r_iss   <= 1'b1;
                            r_c     <= '0;
                            r_best  <= '1;
                            r_state <= ST_FWD;
                        end
                    end
                end

                ST_FWD: begin
                    if (r_iss) begin
                        r_x <= r_x + 1'b1;
                        if (r_x == LAST_X) begin
                            r_iss <= 1'b0;
                        end
                    end
                    if (r_dv) begin
                        r_pre <= pre_val;
                        if (r_dx == LAST_X) begin
                            // r_c keeps the block position of the last column,
                            // where the backward pass begins.
                            r_x     <= LAST_X;
                            r_iss   <= 1'b1;
                            r_state <= ST_BWD;
                        end else begin
                            r_c <= (r_c == (r_w - 8'd1)) ? 8'd0 : (r_c + 8'd1);
                        end
                    end
                end

                ST_BWD: begin
                    if (r_iss) begin
                        r_x <= r_x - 1'b1;
                        if (r_x == '0) begin
                            r_iss <= 1'b0;
                        end
                    end
                    if (r_dv) begin
                        r_suf <= suf_val;
                        r_c   <= (r_c == 8'd0) ? (r_w - 8'd1) : (r_c - 8'd1);
                        // Walking right to left, ties move the choice leftwards.
                        if ((9'(r_dx) <= lim_x) && (9'(score) <= r_best)) begin
                            r_best <= 9'(score);
                            r_bx   <= r_dx;
                        end
                        if (r_dx == '0) begin
                            r_state <= ST_DECIDE;
                        end
                    end
                end

                ST_DECIDE: begin
                    if (fit_sum <= SIZE_9) begin
                        r_new_h           <= fit_sum[HGT_W-1:0];
                        r_x               <= r_bx;
                        r_k               <= r_w;
                        r_res.success     <= 1'b1;
                        r_res.layer_index <= 6'(r_layer);
                        r_res.column_x    <= 8'(r_bx);
                        r_res.row_y       <= r_best[7:0];
                        r_state           <= ST_WRITE;
                    end else if ((7'(r_layer) + 7'd1) == r_used) begin
                        if (r_used == LAYERS_7) begin
                            r_state <= ST_DONE;
                        end else begin
                            r_layer <= r_layer + 1'b1;
                            r_x     <= '0;
                            r_state <= ST_INIT;
                        end
                    end else begin
                        r_layer <= r_layer + 1'b1;
                        r_x     <= '0;
                        r_iss   <= 1'b1;
                        r_c     <= '0;
                        r_best  <= '1;
                        r_state <= ST_FWD;
                    end
                end

                ST_WRITE: begin
                    r_x <= r_x + 1'b1;
                    r_k <= r_k - 8'd1;
                    if (r_k == 8'd1) begin
                        r_state <= ST_DONE;
                    end
                end

                ST_INIT: begin
                    // Opening a fresh layer: the rectangle sits at the origin.
                    r_x <= r_x + 1'b1;
                    if (r_x == LAST_X) begin
                        r_res.success     <= 1'b1;
                        r_res.layer_index <= 6'(r_layer);
                        r_res.column_x    <= '0;
                        r_res.row_y       <= '0;
                        r_used            <= r_used + 7'd1;
                        r_state           <= ST_DONE;
                    end
                end

                ST_DONE: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out               <= out_next;
                        r_out_valid         <= 1'b1;
                        r_state             <= ST_IDLE;
                    end
                end

                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: src/laa_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module laa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

FILE: src/laa_checker.sv
// Port-level checker for the atlas allocator and its bind to the top level.
`include "lightmap_atlas_allocator_unit_macros.svh"

module laa_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input laa_pkg::t_in_beat  i_in_data,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input laa_pkg::t_out_beat o_out_data
);
    import laa_pkg::*;

    // A result beat waiting for the sink keeps its contents.
    `LAA_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_data), "result beat changed while stalled")

    // A failed request reports no position.
    `LAA_ASSERT_ALWAYS(a_fail_zero, i_clk, i_rst_n, !(o_out_valid && !o_out_data.success) || (o_out_data.layer_index == 6'd0 && o_out_data.column_x == 8'd0 && o_out_data.row_y == 8'd0), "failed result carries a position")

    // A placed rectangle lies in a layer counted as in use.
    `LAA_ASSERT_ALWAYS(a_layer_used, i_clk, i_rst_n, !(o_out_valid && o_out_data.success && o_out_data.layers_in_use != 7'd0) || (7'(o_out_data.layer_index) < o_out_data.layers_in_use), "placement outside the layers in use")

    // The used-layer count never exceeds the number of layers.
    `LAA_ASSERT_ALWAYS(a_used_max, i_clk, i_rst_n, !o_out_valid || (o_out_data.layers_in_use <= 7'(NUM_LAYERS)), "layers in use exceeds layer count")

endmodule

bind lightmap_atlas_allocator_unit laa_checker u_laa_checker (.*);
